### src/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, skipped while reset is asserted.
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Checked on every rising edge, reset included.
`define ASSERT_CLK(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) else $error("assertion failed");

`endif

### src/cbcbrc_pkg.sv
package cbcbrc_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned NUM_BYTES = 8;
    localparam int unsigned ROUNDS    = 6;
    localparam int unsigned ROT       = 3;
    localparam int unsigned RND_W     = $clog2(ROUNDS);
    localparam int unsigned BIDX_W    = $clog2(NUM_BYTES);
    localparam int unsigned CFG_IDX_W = 2;

    typedef logic [NUM_BYTES-1:0][BYTE_W-1:0] t_block;
    typedef logic [BYTE_W-1:0]                t_byte;
    typedef logic [CFG_IDX_W-1:0]             t_cfg_idx;

    typedef enum logic {
        MODE_ENC = 1'b0,
        MODE_DEC = 1'b1
    } t_mode;

    localparam t_cfg_idx CFG_MODE = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_KEY  = t_cfg_idx'(1);
    localparam t_cfg_idx CFG_IV   = t_cfg_idx'(2);

endpackage

### src/cbc_byte_rotate_block_cipher_top.sv
// Eight-byte block cipher in CBC mode, one 64-bit block per stream transaction.
// Throughput is one block per clock unless the output stream stalls: a block
// lands in the input register, the whole cipher (chain XOR and six rounds of
// byte XOR/rotate) is evaluated in one combinational pass, and the result and
// next chain value are registered together, so the block behind it already
// sees the updated chain. A block passes the input register and then the
// output register before it is offered on the output; the six-round byte chain
// in cbcbrc_core sets the clock period. restart_chain (tuser) selects the initial
// vector instead of the stored chain value. Configuration writes are always
// accepted; an unknown index is ignored, and writing the initial vector does
// not disturb the chain in progress.
`include "assert_macros.svh"

module cbc_byte_rotate_block_cipher_top (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration write channel
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  cbcbrc_pkg::t_cfg_idx    i_cfg_index,
    input  logic [63:0]             i_cfg_data,
    // input stream
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [63:0]             s_axis_tdata,   // [63:0] block_in
    input  logic                    s_axis_tuser,   // [0] restart_chain
    input  logic                    s_axis_tlast,   // last_block
    // output stream
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [63:0]             m_axis_tdata,   // [63:0] block_out
    output logic                    m_axis_tlast    // last_out
);
    import cbcbrc_pkg::*;

    t_mode  r_mode;
    t_block r_key;
    t_block r_iv;
    t_block r_chain;

    logic   r_in_valid;
    t_block r_in_block;
    logic   r_in_restart;
    logic   r_in_last;

    logic   r_out_valid;
    t_block r_out_block;
    logic   r_out_last;

    logic   w_advance;
    t_block w_chain;
    t_block w_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ENC;
            r_key  <= '0;
            r_iv   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MODE: r_mode <= t_mode'(i_cfg_data[0]);
                CFG_KEY:  r_key  <= t_block'(i_cfg_data);
                CFG_IV:   r_iv   <= t_block'(i_cfg_data);
                default:  ;
            endcase
        end
    end

    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_block   <= t_block'(s_axis_tdata);
            r_in_restart <= s_axis_tuser;
            r_in_last    <= s_axis_tlast;
        end
    end

    assign w_chain = r_in_restart ? r_iv : r_chain;

    cbcbrc_core u_core (
        .i_block  (r_in_block),
        .i_chain  (w_chain),
        .i_key    (r_key),
        .i_mode   (r_mode),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_chain     <= '0;
        end else begin
            if (w_advance) begin
                r_out_valid <= 1'b1;
                // CBC: encrypt chains on ciphertext out, decrypt on ciphertext in
                r_chain     <= (r_mode == MODE_DEC) ? r_in_block : w_result;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_block <= w_result;
            r_out_last  <= r_in_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_block;
    assign m_axis_tlast  = r_out_last;

    `ASSERT_CLK_RST(a_adv_fills_out, i_clk, i_rst_n, w_advance |=> r_out_valid)
    `ASSERT_CLK_RST(a_enc_chain, i_clk, i_rst_n,
        (w_advance && r_mode == MODE_ENC) |=> (r_chain == r_out_block))
    `ASSERT_CLK_RST(a_dec_chain, i_clk, i_rst_n,
        (w_advance && r_mode == MODE_DEC) |=> (r_chain == $past(r_in_block)))
    `ASSERT_CLK(a_stall_full, i_clk, !s_axis_tready |-> (r_in_valid && r_out_valid))

endmodule

### src/cbcbrc_core.sv
// Full cipher pass: chain XOR plus all rounds, encrypt or decrypt.
module cbcbrc_core (
    input  cbcbrc_pkg::t_block i_block,
    input  cbcbrc_pkg::t_block i_chain,
    input  cbcbrc_pkg::t_block i_key,
    input  cbcbrc_pkg::t_mode  i_mode,
    output cbcbrc_pkg::t_block o_result
);
    import cbcbrc_pkg::*;

    function automatic t_byte rotl(t_byte v);
        return t_byte'((v << ROT) | (v >> (BYTE_W - ROT)));
    endfunction

    function automatic t_byte rotr(t_byte v);
        return t_byte'((v >> ROT) | (v << (BYTE_W - ROT)));
    endfunction

    // Byte i of a round uses key byte (i + r) mod 8; the index wraps by width.
    function automatic t_block enc_round(t_block b, t_block key, logic [RND_W-1:0] r);
        t_block            x;
        t_byte             old7;
        t_byte             prev;
        logic [BIDX_W-1:0] kidx;
        x    = b;
        old7 = b[NUM_BYTES-1];
        for (int i = 0; i < NUM_BYTES; i++) begin
            prev = (i == 0) ? old7 : x[i-1];
            kidx = BIDX_W'(i) + BIDX_W'(r);
            x[i] = rotl(x[i] ^ key[kidx]) ^ prev;
        end
        return x;
    endfunction

    function automatic t_block dec_round(t_block b, t_block key, logic [RND_W-1:0] r);
        t_block            x;
        logic [BIDX_W-1:0] kidx;
        logic [BIDX_W-1:0] pidx;
        x = b;
        for (int i = NUM_BYTES - 1; i >= 0; i--) begin
            pidx = BIDX_W'(i) - BIDX_W'(1);
            kidx = BIDX_W'(i) + BIDX_W'(r);
            x[i] = rotr(x[i] ^ x[pidx]) ^ key[kidx];
        end
        return x;
    endfunction

    t_block w_enc [0:ROUNDS];
    t_block w_dec [0:ROUNDS];

    assign w_enc[0] = i_block ^ i_chain;
    assign w_dec[0] = i_block;

    for (genvar g = 0; g < ROUNDS; g++) begin : g_round
        assign w_enc[g+1] = enc_round(w_enc[g], i_key, RND_W'(g));
        assign w_dec[g+1] = dec_round(w_dec[g], i_key, RND_W'(ROUNDS - 1 - g));
    end

    assign o_result = (i_mode == MODE_DEC) ? (w_dec[ROUNDS] ^ i_chain) : w_enc[ROUNDS];

endmodule

### tb/sv/cbc_byte_rotate_block_cipher_top_tb.sv
import cbcbrc_pkg::*;

typedef struct packed {
    logic [63:0] block;
    logic        last;
} t_cipher_result;

class cbc_cipher_model;
    t_mode          mode;
    logic [63:0]    key;
    logic [63:0]    iv;
    logic [63:0]    chain;
    t_cipher_result expected_q[$];
    int             errors;

    function new();
        mode   = MODE_ENC;
        key    = '0;
        iv     = '0;
        chain  = '0;
        errors = 0;
    endfunction

    function t_byte key_byte(int k);
        return key[BYTE_W*(k % NUM_BYTES) +: BYTE_W];
    endfunction

    function logic [63:0] encipher(logic [63:0] x);
        t_block b;
        t_byte  prev;
        t_byte  old7;
        t_byte  v;
        b = x;
        for (int r = 0; r < ROUNDS; r++) begin
            old7 = b[NUM_BYTES-1];
            for (int i = 0; i < NUM_BYTES; i++) begin
                prev = (i == 0) ? old7 : b[i-1];
                v    = b[i] ^ key_byte(i + r);
                b[i] = {v[BYTE_W-ROT-1:0], v[BYTE_W-1:BYTE_W-ROT]} ^ prev;
            end
        end
        return b;
    endfunction

    function logic [63:0] decipher(logic [63:0] x);
        t_block b;
        t_byte  v;
        b = x;
        for (int r = ROUNDS - 1; r >= 0; r--) begin
            for (int i = NUM_BYTES - 1; i >= 0; i--) begin
                // byte 0 pairs with byte 7, which is already restored here
                v    = b[i] ^ b[(i + NUM_BYTES - 1) % NUM_BYTES];
                b[i] = {v[ROT-1:0], v[BYTE_W-1:ROT]} ^ key_byte(i + r);
            end
        end
        return b;
    endfunction

    function void set_reg(t_cfg_idx idx, logic [63:0] data);
        case (idx)
            CFG_MODE: mode = t_mode'(data[0]);
            CFG_KEY:  key  = data;
            CFG_IV:   iv   = data;
            default: ;
        endcase
    endfunction

    function void accept_block(logic [63:0] blk, logic restart, logic last);
        logic [63:0]    link;
        t_cipher_result res;
        link     = restart ? iv : chain;
        res.last = last;
        if (mode == MODE_DEC) begin
            res.block = decipher(blk) ^ link;
            chain     = blk;
        end else begin
            res.block = encipher(blk ^ link);
            chain     = res.block;
        end
        expected_q.push_back(res);
    endfunction

    function void check_block(logic [63:0] blk, logic last);
        t_cipher_result want;
        if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected output block %h last %b", blk, last);
        end else begin
            want = expected_q.pop_front();
            if (want.block !== blk || want.last !== last) begin
                errors++;
                if (errors <= 10)
                    $display("output mismatch: expected %h last %b, got %h last %b",
                             want.block, want.last, blk, last);
            end
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module cbc_byte_rotate_block_cipher_top_tb;

    localparam t_cfg_idx CFG_UNUSED = t_cfg_idx'(3);

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    t_cfg_idx    i_cfg_index   = CFG_MODE;
    logic [63:0] i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tlast;

    bit          src_burst  = 1'b0;
    bit          sink_burst = 1'b0;
    bit          capture_on = 1'b0;
    logic [63:0] cipher_log[$];

    cbc_cipher_model cipher = new();

    cbc_byte_rotate_block_cipher_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // transaction monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                cipher.set_reg(i_cfg_index, i_cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                cipher.accept_block(s_axis_tdata, s_axis_tuser, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) begin
                cipher.check_block(m_axis_tdata, m_axis_tlast);
                if (capture_on)
                    cipher_log.push_back(m_axis_tdata);
            end
        end
    end

    // output side back-pressure
    initial begin : sink
        int gap;
        @(negedge i_clk);
        forever begin
            gap = sink_burst ? 0 : $urandom_range(0, 18);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
            @(negedge i_clk);
        end
    end

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    task automatic send_block(logic [63:0] blk, logic restart, logic last);
        int gap;
        gap = src_burst ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= blk;
        s_axis_tuser  <= restart;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // let every outstanding block come out, plus a little slack for the pipe
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (cipher.pending() > 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // buffers of 1..12 blocks: restart on the first, last on the final one; now and then both flags are random instead
    task automatic send_buffers(int n_items);
        int   left;
        logic rs;
        logic ls;
        left = 0;
        for (int k = 0; k < n_items; k++) begin
            if (left == 0) begin
                left = $urandom_range(1, 12);
                rs   = 1'b1;
            end else begin
                rs   = 1'b0;
            end
            ls = (left == 1);
            if ($urandom_range(0, 6) == 0) begin
                rs = 1'($urandom_range(0, 1));
                ls = 1'($urandom_range(0, 1));
            end
            send_block(rand_word(), rs, ls);
            left--;
        end
    endtask

    task automatic random_phase(int n_items);
        drain();
        src_burst  = ($urandom_range(0, 3) == 0);
        sink_burst = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 1))
            cfg_write(CFG_KEY, rand_word());
        if ($urandom_range(0, 1))
            cfg_write(CFG_IV, rand_word());
        if ($urandom_range(0, 3) == 0)
            cfg_write(CFG_UNUSED, rand_word());
        cfg_write(CFG_MODE, {$urandom(), $urandom()});
        send_buffers(n_items);
    endtask

    initial begin : stimulus
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: encrypt, zero key, zero iv
        send_block('0, 1'b0, 1'b0);
        send_block('1, 1'b0, 1'b1);
        send_block('0, 1'b1, 1'b0);
        drain();

        cfg_write(CFG_KEY, 64'h0123_4567_89AB_CDEF);
        cfg_write(CFG_IV, '1);
        send_block(64'h0011_2233_4455_6677, 1'b1, 1'b0);
        send_block('1, 1'b0, 1'b0);
        send_block('0, 1'b0, 1'b1);
        drain();

        // new iv must not disturb the running chain
        cfg_write(CFG_IV, 64'hDEAD_BEEF_0BAD_F00D);
        send_block(64'h8000_0000_0000_0001, 1'b0, 1'b0);
        send_block(64'h8000_0000_0000_0001, 1'b1, 1'b1);
        drain();

        // decrypt; upper data bits are ignored
        cfg_write(CFG_MODE, '1);
        cfg_write(CFG_KEY, '1);
        send_block('0, 1'b1, 1'b0);
        send_block('1, 1'b0, 1'b0);
        send_block(64'h5A5A_A5A5_0F0F_F0F0, 1'b0, 1'b1);
        drain();

        cfg_write(CFG_UNUSED, '1);
        send_block(64'hFEDC_BA98_7654_3210, 1'b0, 1'b0);
        drain();

        cfg_write(CFG_KEY, '0);
        cfg_write(CFG_MODE, 64'hFFFF_FFFF_FFFF_FFFE);
        send_block('1, 1'b0, 1'b0);
        send_block('0, 1'b1, 1'b1);

        // round trip: encrypt a buffer, then decrypt what came out
        for (int rt = 0; rt < 2; rt++) begin
            drain();
            cfg_write(CFG_KEY, rand_word());
            cfg_write(CFG_IV, rand_word());
            cfg_write(CFG_MODE, 64'(MODE_ENC));
            capture_on = 1'b1;
            for (int j = 0; j < 20; j++)
                send_block(rand_word(), j == 0, j == 19);
            drain();
            capture_on = 1'b0;
            cfg_write(CFG_MODE, 64'(MODE_DEC));
            for (int j = 0; j < cipher_log.size(); j++)
                send_block(cipher_log[j], j == 0, j == cipher_log.size() - 1);
            cipher_log.delete();
        end

        repeat (7) random_phase(45);

        drain();
        repeat (10) @(negedge i_clk);
        if (cipher.errors == 0 && cipher.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### filelist.f
+incdir+src
src/cbcbrc_pkg.sv
src/cbcbrc_core.sv
src/cbc_byte_rotate_block_cipher_top.sv
tb/sv/cbc_byte_rotate_block_cipher_top_tb.sv
